// ----- design/dsr_pkg.sv -----
// Shared definitions for the deque stack with rotate: request and status codes,
// plus the command and status bundles between the controller and the datapath.
// No dependencies.
`default_nettype none

package dsr_pkg;

  localparam int unsigned ReqW    = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;

  // Request codes carried in the input tuser.
  localparam logic [ReqW-1:0] REQ_PUSH = 3'd0;
  localparam logic [ReqW-1:0] REQ_POP  = 3'd1;
  localparam logic [ReqW-1:0] REQ_SWAP = 3'd2;
  localparam logic [ReqW-1:0] REQ_ROT  = 3'd3;
  localparam logic [ReqW-1:0] REQ_RROT = 3'd4;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

  // Controller to datapath: one strobe per micro step.
  typedef struct packed {
    logic accept;  // input transfer: latch request, first read, push write
    logic sw_rd2;  // swap: keep top value, read second entry
    logic sw_wr1;  // swap: write second value into the top slot
    logic sw_wr2;  // swap: write old top value into the second slot
    logic rot_wb;  // rotate or reverse rotate: write back and move top
    logic out_ld;  // load the output register
  } dsr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic push_ok;  // incoming request is a push with room
    logic pop_ok;   // incoming request is a pop with an entry
    logic swap_ok;  // incoming request is a swap with two or more entries
    logic rot_ok;   // incoming request is a rotate of either kind with two or more
    logic out_free; // output register can take a result this cycle
  } dsr_sts_t;

endpackage

`default_nettype wire

// ----- design/dsr_ctrl.sv -----
// Sequencer for the deque stack with rotate: steps each request through its
// memory accesses and hands the result to the output register. Uses dsr_pkg.
`default_nettype none

module dsr_ctrl
  import dsr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dsr_sts_t sts_i,
  output dsr_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SW1  = 3'd1;
  localparam logic [2:0] S_SW2  = 3'd2;
  localparam logic [2:0] S_SW3  = 3'd3;
  localparam logic [2:0] S_RWB  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          if (sts_i.swap_ok) begin
            state_d = S_SW1;
          end else if (sts_i.rot_ok) begin
            state_d = S_RWB;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_SW1: begin
        cmd_o.sw_rd2 = 1'b1;
        state_d      = S_SW2;
      end
      S_SW2: begin
        cmd_o.sw_wr1 = 1'b1;
        state_d      = S_SW3;
      end
      S_SW3: begin
        cmd_o.sw_wr2 = 1'b1;
        state_d      = S_FIN;
      end
      S_RWB: begin
        cmd_o.rot_wb = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/dsr_datapath.sv -----
// Datapath of the deque stack with rotate: ring store memory, top pointer,
// entry count, scratch registers and the output register. Uses dsr_pkg.
`default_nettype none

module dsr_datapath
  import dsr_pkg::*;
#(
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [ReqW-1:0]                   req_i,
  input  wire logic signed [ValueW-1:0]          push_value_i,
  input  wire dsr_cmd_t                          cmd_i,
  output dsr_sts_t                               sts_o,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic signed [ValueW-1:0]               popped_value_o,
  output logic                                   popped_valid_o,
  output logic [StatusW-1:0]                     status_o,
  output logic [$clog2(DEPTH+1)-1:0]             entry_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW:0]   DEPTH_X  = (CW + 1)'(DEPTH);

  logic [ValueW-1:0] mem_q [DEPTH];

  logic [AW-1:0]      top_q;
  logic [CW-1:0]      cnt_q;
  logic [ValueW-1:0]  rdata_q;
  logic [ValueW-1:0]  tmp_q;
  logic               rot_fwd_q;
  logic               pop_q;
  logic [StatusW-1:0] st_q;

  logic               out_valid_q;
  logic [ValueW-1:0]  out_value_q;
  logic               out_pop_q;
  logic [StatusW-1:0] out_st_q;
  logic [CW-1:0]      out_cnt_q;

  logic [AW-1:0]      top_next, top_prev, rot_slot, bottom;
  logic [CW:0]        sum_rot, sum_bot;
  logic               is_full, is_empty, ge2;
  logic [StatusW-1:0] st_d;

  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [ValueW-1:0]  wr_data;

  // Ring arithmetic: every sum stays below twice the depth, so one compare
  // and subtract wraps it.
  assign top_next = (top_q == LAST_IDX) ? '0 : top_q + AW'(1);
  assign top_prev = (top_q == '0) ? LAST_IDX : top_q - AW'(1);
  assign sum_rot  = {{(CW + 1 - AW){1'b0}}, top_q} + {1'b0, cnt_q};
  assign sum_bot  = sum_rot - (CW + 1)'(1);
  assign rot_slot = (sum_rot >= DEPTH_X) ? AW'(sum_rot - DEPTH_X) : AW'(sum_rot);
  assign bottom   = (sum_bot >= DEPTH_X) ? AW'(sum_bot - DEPTH_X) : AW'(sum_bot);

  assign is_full  = (cnt_q == FULL_CNT);
  assign is_empty = (cnt_q == '0);
  assign ge2      = (cnt_q >= CW'(2));

  always_comb begin
    sts_o          = '0;
    sts_o.out_free = !out_valid_q || out_ready_i;
    st_d           = ST_OK;
    unique case (req_i) inside
      REQ_PUSH: begin
        sts_o.push_ok = !is_full;
        if (is_full) begin
          st_d = ST_FULL;
        end
      end
      REQ_POP: begin
        sts_o.pop_ok = !is_empty;
        if (is_empty) begin
          st_d = ST_EMPTY;
        end
      end
      REQ_SWAP:          sts_o.swap_ok = ge2;
      REQ_ROT, REQ_RROT: sts_o.rot_ok  = ge2;
      default:           st_d = ST_OK;
    endcase
  end

  // Memory port selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = top_prev;
    wr_data = push_value_i;
    if (cmd_i.accept && sts_o.push_ok) begin
      wr_en = 1'b1;
    end else if (cmd_i.sw_wr1) begin
      wr_en   = 1'b1;
      wr_addr = top_q;
      wr_data = rdata_q;
    end else if (cmd_i.sw_wr2) begin
      wr_en   = 1'b1;
      wr_addr = top_next;
      wr_data = tmp_q;
    end else if (cmd_i.rot_wb) begin
      wr_en   = 1'b1;
      wr_addr = rot_fwd_q ? rot_slot : top_prev;
      wr_data = rdata_q;
    end
  end

  assign rd_en   = cmd_i.accept || cmd_i.sw_rd2;
  assign rd_addr = cmd_i.sw_rd2 ? top_next : ((req_i == REQ_RROT) ? bottom : top_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Pointer and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.accept && sts_o.push_ok) begin
      top_q <= top_prev;
      cnt_q <= cnt_q + CW'(1);
    end else if (cmd_i.accept && sts_o.pop_ok) begin
      top_q <= top_next;
      cnt_q <= cnt_q - CW'(1);
    end else if (cmd_i.rot_wb) begin
      top_q <= rot_fwd_q ? top_next : top_prev;
    end
  end

  // Per-request scratch.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rot_fwd_q <= (req_i == REQ_ROT);
      pop_q     <= sts_o.pop_ok;
      st_q      <= st_d;
    end
    if (cmd_i.sw_rd2) begin
      tmp_q <= rdata_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_value_q <= pop_q ? rdata_q : '0;
      out_pop_q   <= pop_q;
      out_st_q    <= st_q;
      out_cnt_q   <= cnt_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = out_value_q;
  assign popped_valid_o = out_pop_q;
  assign status_o       = out_st_q;
  assign entry_count_o  = out_cnt_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT)
    else $error("entry count exceeds depth");

  a_full_push_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && req_i == REQ_PUSH && is_full) |=> $stable(cnt_q) && $stable(top_q))
    else $error("push on full changed the stack");

  a_rot_keeps_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rot_wb |=> $stable(cnt_q))
    else $error("rotate changed the entry count");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_ld |=> out_valid_q)
    else $error("loaded result not presented");

  a_pop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_pop_q) |-> (out_st_q == ST_OK))
    else $error("popped entry with error status");

endmodule

`default_nettype wire

// ----- design/deque_stack_with_rotate.sv -----
// Top level of the deque stack with rotate: joins the sequencer and the
// datapath and packs the stream channels. Uses dsr_pkg, dsr_ctrl, dsr_datapath.
//
// Usage. Requests arrive on the s_axis channel: tuser carries the request
// code (push, pop, swap, rotate, reverse rotate) and tdata the value a push
// places on top. Every request gives exactly one result transfer on the
// m_axis channel, in request order, carrying the popped value (zero unless a
// pop removed an entry), the status code and the entry count after the
// request; tuser marks a result that holds a removed entry.
//
// Sequencing. One request is worked on at a time, and the steps from the input
// transfer to the result being presented are set by the accesses to the
// single-read, single-write ring store: push, pop, error cases and no-ops
// are done at the input transfer, rotate and reverse rotate add a write back,
// and swap reads top, reads second and makes two writes. The next request is
// taken in the cycle after a result is loaded, never while one is in progress.
//
// Reset clears the top pointer, the entry count and the output valid; the
// store itself is not cleared and needs no clearing pass. When the receiver
// stalls, the result waits in the output register; the next request is still
// taken and worked through, and then waits for the register to drain.
`default_nettype none

module deque_stack_with_rotate
  import dsr_pkg::*;
#(
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Request channel.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [ValueW-1:0]     s_axis_tdata,  // [31:0] push_value
  input  wire logic [ReqW-1:0]       s_axis_tuser,  // [2:0] req_type
  // Result channel.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [31:0] popped_value, [33:32] status, then entry_count, zero fill to bytes
  output logic [((ValueW + StatusW + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic [0:0]                 m_axis_tuser   // [0] popped_valid
);

  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned PackW = ValueW + StatusW + CW;
  localparam int unsigned OutW  = ((PackW + 7) / 8) * 8;

  dsr_cmd_t                  cmd;
  dsr_sts_t                  sts;
  logic signed [ValueW-1:0]  push_value;
  logic signed [ValueW-1:0]  popped_value;
  logic                      popped_valid;
  logic [StatusW-1:0]        status;
  logic [CW-1:0]             entry_count;

  assign push_value = s_axis_tdata;

  dsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dsr_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (s_axis_tuser),
    .push_value_i   (push_value),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .popped_value_o (popped_value),
    .popped_valid_o (popped_valid),
    .status_o       (status),
    .entry_count_o  (entry_count)
  );

  // Fields packed from the lowest bit up, zero filled to whole bytes.
  assign m_axis_tdata = OutW'({entry_count, status, popped_value});
  assign m_axis_tuser = popped_valid;

endmodule

`default_nettype wire
